// ----- rtl/mrr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mrr_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_REDUCE,
    ST_POW,
    ST_MUL_ACC,
    ST_SQR_BASE,
    ST_CHECK,
    ST_LOOP,
    ST_SQR_X,
    ST_FIN
  } mrr_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mrr_mm_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mrr_mulmod.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrr_mulmod
  import mrr_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] m,
  output mrr_mm_stat_t          stat,
  output logic      [WIDTH-1:0] res
);

  localparam int CW = $clog2(2*WIDTH+1);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [2*WIDTH-1:0]   prod_r;
  logic [WIDTH-1:0]     m_r;
  logic [WIDTH-1:0]     rem_r;
  logic [WIDTH-1:0]     rem_nxt;
  logic [WIDTH:0]       shifted;
  logic [WIDTH:0]       diff;

  // One quotient bit per cycle: shift in the next product bit, subtract when it fits.
  assign shifted = {rem_r, prod_r[2*WIDTH-1]};
  assign diff    = shifted - {1'b0, m_r};
  assign rem_nxt = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(2*WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
      m_r    <= m;
      rem_r  <= '0;
    end else if (busy_r) begin
      prod_r <= {prod_r[2*WIDTH-2:0], 1'b0};
      rem_r  <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = rem_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("reduction done while still busy");

  a_start_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && cnt_r == CW'(2*WIDTH)))
    else $error("start did not load the step count");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("busy with an exhausted step count");

endmodule

`default_nettype wire

// ----- rtl/miller_rabin_round_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One Miller-Rabin round on a WIDTH-bit candidate with a caller-supplied witness.
// The input channel takes a beat of candidate and witness; the result channel returns
// one beat per input with probably_prime and trivial_case.
// Candidates below 2, equal to 2 or 3, or even are decided at once: they go from idle
// to the finish state and from there into the output register.
// Other candidates run on one shared modular multiplier: a WIDTH by WIDTH product
// followed by a bit-serial remainder.
// Their run is made of M multiplies, where r is the number of trailing zeros of n-1:
// one witness reduction, one or two per exponent bit of d, and up to r-1 further
// squarings. The input stays not ready until the current item has left the sequencer.
// A finished result waits in the output register while the next item is accepted;
// if the receiver stalls, the following result holds in the sequencer until taken.
// Reset (rst_n low at a clock edge) empties the output register and returns to idle.

module miller_rabin_round_top
  import mrr_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FIELD_W-1:0] in_candidate,
  input  wire logic [FIELD_W-1:0] in_witness,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_probably_prime,
  output logic                    out_trivial_case
);

  localparam int RW = $clog2(WIDTH);

  mrr_state_t       state_r;
  mrr_state_t       state_nxt;
  logic [WIDTH-1:0] n_r;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] base_r;
  logic [RW-1:0]    r_r;
  logic [RW-1:0]    j_r;
  logic             pass_r;
  logic             triv_r;
  logic             out_valid_r;
  logic             out_pp_r;
  logic             out_tc_r;

  logic [WIDTH-1:0] n_in;
  logic [WIDTH-1:0] nm1;
  logic             is_small_prime;
  logic             is_triv;
  logic             in_acc;
  logic             out_free;
  logic             round_pass;

  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic [WIDTH-1:0] mm_res;
  mrr_mm_stat_t     mm_stat;

  assign n_in           = in_candidate[WIDTH-1:0];
  assign is_small_prime = (n_in == WIDTH'(2)) || (n_in == WIDTH'(3));
  assign is_triv        = (n_in < WIDTH'(2)) || is_small_prime || !n_in[0];
  assign in_acc         = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign nm1            = n_r - WIDTH'(1);
  assign round_pass     = (acc_r == WIDTH'(1)) || (acc_r == nm1);

  mrr_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mm_start),
    .a    (mm_a),
    .b    (mm_b),
    .m    (n_r),
    .stat (mm_stat),
    .res  (mm_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = is_triv ? ST_FIN : ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (d_r[0]) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        priority if (d_r == '0) begin
          state_nxt = ST_CHECK;
        end else if (d_r[0]) begin
          state_nxt = ST_MUL_ACC;
        end else begin
          state_nxt = ST_SQR_BASE;
        end
      end
      ST_MUL_ACC: begin
        if (mm_stat.done) begin
          state_nxt = ST_SQR_BASE;
        end
      end
      ST_SQR_BASE: begin
        if (mm_stat.done) begin
          state_nxt = ST_POW;
        end
      end
      ST_CHECK: begin
        state_nxt = round_pass ? ST_FIN : ST_LOOP;
      end
      ST_LOOP: begin
        state_nxt = (j_r < r_r) ? ST_SQR_X : ST_FIN;
      end
      ST_SQR_X: begin
        if (mm_stat.done) begin
          state_nxt = (mm_res == nm1) ? ST_FIN : ST_LOOP;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mm_start = 1'b0;
    mm_a     = acc_r;
    mm_b     = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_REDUCE: begin
        mm_start = !mm_stat.busy && !mm_stat.done;
        mm_a     = a_r;
        mm_b     = WIDTH'(1);
      end
      ST_MUL_ACC: begin
        mm_start = !mm_stat.busy && !mm_stat.done;
        mm_a     = acc_r;
        mm_b     = base_r;
      end
      ST_SQR_BASE: begin
        mm_start = !mm_stat.busy && !mm_stat.done;
        mm_a     = base_r;
        mm_b     = base_r;
      end
      ST_SQR_X: begin
        mm_start = !mm_stat.busy && !mm_stat.done;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r    <= n_in;
      a_r    <= in_witness[WIDTH-1:0];
      d_r    <= n_in - WIDTH'(1);
      r_r    <= '0;
      acc_r  <= WIDTH'(1);
      pass_r <= is_small_prime;
      triv_r <= is_triv;
    end
    unique case (state_r)
      ST_STRIP: begin
        if (!d_r[0]) begin
          d_r <= d_r >> 1;
          r_r <= r_r + RW'(1);
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          base_r <= mm_res;
        end
      end
      ST_MUL_ACC: begin
        if (mm_stat.done) begin
          acc_r <= mm_res;
        end
      end
      ST_SQR_BASE: begin
        if (mm_stat.done) begin
          base_r <= mm_res;
          d_r    <= d_r >> 1;
        end
      end
      ST_CHECK: begin
        pass_r <= round_pass;
        j_r    <= RW'(1);
      end
      ST_SQR_X: begin
        if (mm_stat.done) begin
          acc_r <= mm_res;
          j_r   <= j_r + RW'(1);
          if (mm_res == nm1) begin
            pass_r <= 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_pp_r <= pass_r;
          out_tc_r <= triv_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_probably_prime = out_pp_r;
  assign out_trivial_case   = out_tc_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_stat.busy)
    else $error("multiply started while the unit is busy");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_FIN || state_r == ST_STRIP))
    else $error("accepted beat did not enter the round");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not moved to the output register");

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!mm_stat.busy && !mm_stat.done))
    else $error("multiplier active while idle");

endmodule

`default_nettype wire

// ----- dv/miller_rabin_round_top_test.sv -----
`timescale 1ns / 1ps

module miller_rabin_round_top_test;
  import mrr_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int LONG_HOLD = 400;
  localparam int BURST_LEN = 12;
  localparam int RANDOM_ITEMS = 255;

  typedef struct {
    logic [FIELD_W-1:0] cand;
    logic [FIELD_W-1:0] wit;
    bit drain;
  } round_req_t;

  typedef struct {
    bit prime;
    bit trivial;
    logic [FIELD_W-1:0] cand;
    logic [FIELD_W-1:0] wit;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [FIELD_W-1:0] in_candidate;
  logic [FIELD_W-1:0] in_witness;
  logic out_valid;
  logic out_ready;
  logic out_probably_prime;
  logic out_trivial_case;

  round_req_t pending_rounds[$];
  verdict_t verdicts_due[$];
  bit in_beat;
  int n_sent;
  int n_errors;
  int in_gap;
  int rx_stall;
  int burst_at;
  bit long_hold_done;
  longint unsigned cycles;
  verdict_t want;

  miller_rabin_round_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_candidate(in_candidate),
    .in_witness(in_witness),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_probably_prime(out_probably_prime),
    .out_trivial_case(out_trivial_case)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic verdict_t mr_round_verdict(logic [FIELD_W-1:0] n, logic [FIELD_W-1:0] a);
    verdict_t v;
    logic [63:0] modulus, nm1, odd_part, e, base, acc, x;
    int r;
    int j;
    bit pass;
    v.cand = n;
    v.wit = a;
    v.trivial = 1'b1;
    v.prime = 1'b0;
    if (n < 2) return v;
    if (n == 2 || n == 3) begin
      v.prime = 1'b1;
      return v;
    end
    if (!n[0]) return v;
    v.trivial = 1'b0;
    modulus = {32'd0, n};
    nm1 = modulus - 1;
    odd_part = nm1;
    r = 0;
    while (!odd_part[0]) begin
      odd_part = odd_part >> 1;
      r++;
    end
    base = {32'd0, a} % modulus;
    acc = 64'd1;
    e = odd_part;
    while (e != 0) begin
      if (e[0]) acc = (acc * base) % modulus;
      base = (base * base) % modulus;
      e = e >> 1;
    end
    x = acc;
    pass = (x == 1 || x == nm1);
    for (j = 1; !pass && j < r; j++) begin
      x = (x * x) % modulus;
      if (x == nm1) pass = 1'b1;
    end
    v.prime = pass;
    return v;
  endfunction

  function automatic int idle_len(bit calm);
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic bit calm_phase(int sent);
    return ((sent / 40) % 3) == 1;
  endfunction

  task automatic queue_round(logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] w, bit drain);
    round_req_t req;
    req.cand = c;
    req.wit = w;
    req.drain = drain;
    pending_rounds = {pending_rounds, req};
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Monitor: inputs are stable here since they only change at the falling edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result beat: prime=%0b trivial=%0b",
                     out_probably_prime, out_trivial_case);
        end else begin
          want = verdicts_due.pop_front();
          if (out_probably_prime !== want.prime || out_trivial_case !== want.trivial) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch n=%0d a=%0d: expected prime=%0b trivial=%0b, got %0b %0b",
                       want.cand, want.wit, want.prime, want.trivial,
                       out_probably_prime, out_trivial_case);
          end
        end
      end
      in_beat = in_valid && in_ready;
      if (in_beat) begin
        verdicts_due = {verdicts_due, mr_round_verdict(in_candidate, in_witness)};
        n_sent++;
      end
    end
  end

  always @(negedge clk) begin : driver
    logic nxt_valid;
    round_req_t req;
    if (rst_n) begin
      nxt_valid = in_valid;
      if (in_beat) begin
        nxt_valid = 1'b0;
        in_gap = idle_len(calm_phase(n_sent));
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_rounds.size() != 0 &&
                     !(pending_rounds[0].drain && verdicts_due.size() != 0)) begin
          req = pending_rounds.pop_front();
          in_candidate <= req.cand;
          in_witness <= req.wit;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_stall == 0) begin
        if (!long_hold_done && n_sent > burst_at) begin
          long_hold_done = 1'b1;
          rx_stall = LONG_HOLD;
        end else if (!calm_phase(n_sent) && $urandom_range(0, 99) < 25) begin
          rx_stall = idle_len(1'b0);
        end
      end
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int k;
    int i;
    int total_items;
    logic [FIELD_W-1:0] c;
    logic [FIELD_W-1:0] w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_candidate = '0;
    in_witness = '0;
    out_ready = 1'b0;
    in_beat = 1'b0;
    n_sent = 0;
    n_errors = 0;
    in_gap = 0;
    rx_stall = 0;
    cycles = 0;
    long_hold_done = 1'b0;
    burst_at = 1 << 30;

    queue_round(32'd0, 32'd5, 1'b0);
    queue_round(32'd1, 32'hFFFF_FFFF, 1'b0);
    queue_round(32'd2, 32'd0, 1'b0);
    queue_round(32'd3, 32'hFFFF_FFFF, 1'b0);
    queue_round(32'd4, 32'd2, 1'b0);
    queue_round(32'hFFFF_FFFE, 32'd7, 1'b0);
    queue_round(32'd5, 32'd2, 1'b0);
    queue_round(32'd5, 32'd3, 1'b0);
    queue_round(32'd7, 32'd0, 1'b0);
    queue_round(32'd97, 32'd1, 1'b0);
    queue_round(32'd97, 32'd96, 1'b0);
    queue_round(32'd97, 32'd97, 1'b0);
    queue_round(32'd101, 32'hFFFF_FFFF, 1'b0);
    queue_round(32'd25, 32'd7, 1'b0);
    queue_round(32'd561, 32'd2, 1'b0);
    queue_round(32'd2047, 32'd2, 1'b0);
    queue_round(32'd3215031751, 32'd2, 1'b0);
    queue_round(32'd65537, 32'd3, 1'b0);
    queue_round(32'h8000_0001, 32'd12345, 1'b0);
    queue_round(32'hFFFF_FFFB, 32'd2, 1'b0);
    queue_round(32'hFFFF_FFFB, 32'hFFFF_FFF9, 1'b0);
    queue_round(32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b0);

    // A burst of quick trivial beats behind a drained pipeline, during which the
    // receiver holds off long enough for the input side to back up.
    burst_at = pending_rounds.size();
    for (i = 0; i < BURST_LEN; i++)
      queue_round($urandom & 32'hFFFF_FFFE, $urandom, i == 0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        c = $urandom_range(0, 1) ? $urandom_range(0, 3) : ($urandom & 32'hFFFF_FFFE);
        w = $urandom;
      end else if (kind < 70) begin
        k = $urandom_range(4, 16);
        c = $urandom_range(5, (1 << k) - 1) | 32'd1;
        w = 2 + $urandom_range(0, c - 4);
      end else if (kind < 90) begin
        c = $urandom | 32'd1;
        if (c < 5) c = 32'd5;
        w = 2 + ($urandom % (c - 3));
      end else begin
        c = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200);
        case ($urandom_range(0, 3))
          0: w = $urandom;
          1: w = c * $urandom_range(0, 3);
          2: w = c - 1;
          default: w = 32'd1;
        endcase
      end
      queue_round(c, w, $urandom_range(0, 99) < 2);
    end
    total_items = pending_rounds.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_sent < total_items || verdicts_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (n_errors == 0 && verdicts_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
